[hw/rtl/vertex_rotate_project_defines.svh]
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VRP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VRP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vrp_pkg.sv]
`timescale 1ns / 1ps

package vrp_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 1600;
    localparam int SCREEN_HEIGHT = 900;
    localparam int MIN_SIDE      = (SCREEN_HEIGHT < SCREEN_WIDTH) ? SCREEN_HEIGHT : SCREEN_WIDTH;
    localparam int SIDE_W        = $clog2(4096 + 1);

    // Field widths
    localparam int IN_W   = 32;
    localparam int COEF_W = 16;
    localparam int FRAC_W = 16;
    localparam int RND_SH = 14;

    // Rotation about X
    localparam int P1_W   = IN_W + COEF_W;
    localparam int SUM1_W = P1_W + 1;
    localparam int Y1_W   = SUM1_W - RND_SH;

    // Rotation about Y
    localparam int P2_W   = Y1_W + COEF_W;
    localparam int SUM2_W = P2_W + 1;
    localparam int X2_W   = SUM2_W - RND_SH;

    // Translation
    localparam int XT_W = X2_W + 1;
    localparam int YT_W = Y1_W + 1;
    localparam int ZT_W = X2_W + 1;

    // Division
    localparam int NUM_W  = XT_W + FRAC_W;
    localparam int DEN_W  = ZT_W;
    localparam int QB     = 41;
    localparam int TOP_W  = NUM_W - QB;
    localparam logic [QB-1:0] Q_LIMIT = {1'b1, {(QB - 1){1'b0}}};

    // Screen mapping
    localparam int QS_W  = QB + 1;
    localparam int PR_W  = QS_W + SIDE_W + 1;
    localparam int SCR_W = PR_W + 1;
    localparam logic signed [SCR_W-1:0] HALF_W_Q = SCR_W'(SCREEN_WIDTH * 32768);
    localparam logic signed [SCR_W-1:0] HALF_H_Q = SCR_W'(SCREEN_HEIGHT * 32768);
    localparam logic signed [SCR_W-1:0] SAT_HI = {{(SCR_W - 32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [SCR_W-1:0] SAT_LO = {{(SCR_W - 32){1'b1}}, 32'h8000_0000};

    // Configuration
    localparam int IDX_W = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_PITCH_COS,
        REG_PITCH_SIN,
        REG_YAW_COS,
        REG_YAW_SIN,
        REG_TRANSLATE_X,
        REG_TRANSLATE_Y,
        REG_TRANSLATE_Z
    } vrp_reg_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] pitch_cos;
        logic signed [COEF_W-1:0] pitch_sin;
        logic signed [COEF_W-1:0] yaw_cos;
        logic signed [COEF_W-1:0] yaw_sin;
        logic signed [IN_W-1:0]   translate_x;
        logic signed [IN_W-1:0]   translate_y;
        logic signed [IN_W-1:0]   translate_z;
    } vrp_cfg_t;

    // Rotate/translate to divider
    typedef struct packed {
        logic [NUM_W-1:0] nx;
        logic [NUM_W-1:0] ny;
        logic [DEN_W-1:0] d;
        logic             negx;
        logic             negy;
        logic             grd;
    } vrp_div_in_t;

    // Divider to screen mapping
    typedef struct packed {
        logic [QB-1:0] qx;
        logic [QB-1:0] qy;
        logic          ovfx;
        logic          ovfy;
        logic          negx;
        logic          negy;
        logic          grd;
    } vrp_div_out_t;

endpackage

[hw/rtl/vrp_rotate.sv]
`timescale 1ns / 1ps

module vrp_rotate (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vrp_pkg::vrp_cfg_t                cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [vrp_pkg::IN_W-1:0]  vx,
    input  logic signed [vrp_pkg::IN_W-1:0]  vy,
    input  logic signed [vrp_pkg::IN_W-1:0]  vz,
    output logic                             out_valid,
    input  logic                             out_ready,
    output vrp_pkg::vrp_div_in_t             out_data
);

    localparam int NS = 6;

    localparam logic signed [vrp_pkg::SUM1_W-1:0] RND1 =
        vrp_pkg::SUM1_W'(1) << (vrp_pkg::RND_SH - 1);
    localparam logic signed [vrp_pkg::SUM2_W-1:0] RND2 =
        vrp_pkg::SUM2_W'(1) << (vrp_pkg::RND_SH - 1);

    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] up_vld;
    logic [NS-1:0] ld;

    assign rdy[NS] = out_ready;
    assign up_vld  = {vld_reg[NS-2:0], in_valid};

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_hs
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
            assign ld[k]  = rdy[k] && up_vld[k];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (up_vld & rdy[NS-1:0]) | (vld_reg & ~rdy[NS-1:0]);
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NS-1];

    // Stage 1: pitch products
    logic signed [vrp_pkg::P1_W-1:0] p_yc_reg, p_zs_reg, p_ys_reg, p_zc_reg;
    logic signed [vrp_pkg::IN_W-1:0] x1_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            p_yc_reg <= vy * cfg.pitch_cos;
            p_zs_reg <= vz * cfg.pitch_sin;
            p_ys_reg <= vy * cfg.pitch_sin;
            p_zc_reg <= vz * cfg.pitch_cos;
            x1_reg   <= vx;
        end
    end

    // Stage 2: round y1, z1
    logic signed [vrp_pkg::SUM1_W-1:0] y1_sum, z1_sum;
    logic signed [vrp_pkg::Y1_W-1:0]   y1_reg, z1_reg;
    logic signed [vrp_pkg::IN_W-1:0]   x2_reg;

    assign y1_sum = p_yc_reg - p_zs_reg + RND1;
    assign z1_sum = p_ys_reg + p_zc_reg + RND1;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            y1_reg <= y1_sum[vrp_pkg::SUM1_W-1:vrp_pkg::RND_SH];
            z1_reg <= z1_sum[vrp_pkg::SUM1_W-1:vrp_pkg::RND_SH];
            x2_reg <= x1_reg;
        end
    end

    // Stage 3: yaw products
    logic signed [vrp_pkg::P2_W-1:0] p_xc_reg, p_zs2_reg, p_zc2_reg, p_xs_reg;
    logic signed [vrp_pkg::Y1_W-1:0] y3_reg;

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            p_xc_reg  <= x2_reg * cfg.yaw_cos;
            p_zs2_reg <= z1_reg * cfg.yaw_sin;
            p_zc2_reg <= z1_reg * cfg.yaw_cos;
            p_xs_reg  <= x2_reg * cfg.yaw_sin;
            y3_reg    <= y1_reg;
        end
    end

    // Stage 4: round x2, z2
    logic signed [vrp_pkg::SUM2_W-1:0] x2_sum, z2_sum;
    logic signed [vrp_pkg::X2_W-1:0]   xr_reg, zr_reg;
    logic signed [vrp_pkg::Y1_W-1:0]   y4_reg;

    assign x2_sum = p_xc_reg + p_zs2_reg + RND2;
    assign z2_sum = p_zc2_reg - p_xs_reg + RND2;

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            xr_reg <= x2_sum[vrp_pkg::SUM2_W-1:vrp_pkg::RND_SH];
            zr_reg <= z2_sum[vrp_pkg::SUM2_W-1:vrp_pkg::RND_SH];
            y4_reg <= y3_reg;
        end
    end

    // Stage 5: translate
    logic signed [vrp_pkg::XT_W-1:0] xt_reg;
    logic signed [vrp_pkg::YT_W-1:0] yt_reg;
    logic signed [vrp_pkg::ZT_W-1:0] zt_reg;
    logic signed [vrp_pkg::XT_W-1:0] xt_next;
    logic signed [vrp_pkg::YT_W-1:0] yt_next;
    logic signed [vrp_pkg::ZT_W-1:0] zt_next;

    assign xt_next = xr_reg + cfg.translate_x;
    assign yt_next = y4_reg + cfg.translate_y;
    assign zt_next = zr_reg + cfg.translate_z;

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            xt_reg <= xt_next;
            yt_reg <= yt_next;
            zt_reg <= zt_next;
        end
    end

    // Stage 6: guard zero depth, split into sign and magnitude
    logic                            zero_z;
    logic signed [vrp_pkg::ZT_W-1:0] zg;
    logic signed [vrp_pkg::NUM_W-1:0] numx, numy;
    vrp_pkg::vrp_div_in_t            div_next;
    vrp_pkg::vrp_div_in_t            div_reg;

    always_comb
    begin
        zero_z = (zt_reg == '0);
        zg     = zero_z ? vrp_pkg::ZT_W'(1) : zt_reg;
        numx   = {xt_reg, {vrp_pkg::FRAC_W{1'b0}}};
        numy   = {{(vrp_pkg::NUM_W - vrp_pkg::YT_W - vrp_pkg::FRAC_W){yt_reg[vrp_pkg::YT_W-1]}},
                  yt_reg, {vrp_pkg::FRAC_W{1'b0}}};
        div_next.nx   = numx[vrp_pkg::NUM_W-1] ? vrp_pkg::NUM_W'(-numx) : numx;
        div_next.ny   = numy[vrp_pkg::NUM_W-1] ? vrp_pkg::NUM_W'(-numy) : numy;
        div_next.d    = zg[vrp_pkg::ZT_W-1] ? vrp_pkg::DEN_W'(-zg) : zg;
        div_next.negx = numx[vrp_pkg::NUM_W-1] ^ zg[vrp_pkg::ZT_W-1];
        div_next.negy = numy[vrp_pkg::NUM_W-1] ^ zg[vrp_pkg::ZT_W-1];
        div_next.grd  = zero_z;
    end

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            div_reg <= div_next;
        end
    end

    assign out_data = div_reg;

endmodule

[hw/rtl/vrp_divide.sv]
`timescale 1ns / 1ps

module vrp_divide (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vrp_pkg::vrp_div_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vrp_pkg::vrp_div_out_t out_data
);

    localparam int NS = vrp_pkg::QB + 1;

    typedef struct packed {
        logic [vrp_pkg::DEN_W-1:0] rx;
        logic [vrp_pkg::DEN_W-1:0] ry;
        logic [vrp_pkg::QB-1:0]    qx;
        logic [vrp_pkg::QB-1:0]    qy;
        logic [vrp_pkg::NUM_W-1:0] nx;
        logic [vrp_pkg::NUM_W-1:0] ny;
        logic [vrp_pkg::DEN_W-1:0] d;
        logic                      negx;
        logic                      negy;
        logic                      grd;
        logic                      ovfx;
        logic                      ovfy;
    } vrp_dst_t;

    // One restoring step: returns {quotient bit, new remainder}
    function automatic logic [vrp_pkg::DEN_W:0] div_step(
        input logic [vrp_pkg::DEN_W-1:0] rem,
        input logic                      nbit,
        input logic [vrp_pkg::DEN_W-1:0] d
    );
        logic [vrp_pkg::DEN_W:0] sh;
        logic [vrp_pkg::DEN_W:0] diff;
        logic                    ge;
        sh   = {rem, nbit};
        diff = sh - {1'b0, d};
        ge   = (sh >= {1'b0, d});
        return {ge, ge ? diff[vrp_pkg::DEN_W-1:0] : sh[vrp_pkg::DEN_W-1:0]};
    endfunction

    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] up_vld;
    logic [NS-1:0] ld;
    vrp_dst_t      st_reg  [NS];
    vrp_dst_t      st_next [NS];

    assign rdy[NS] = out_ready;
    assign up_vld  = {vld_reg[NS-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (up_vld & rdy[NS-1:0]) | (vld_reg & ~rdy[NS-1:0]);
        end
    end

    // Seed remainder with the top dividend bits; a seed at or above the
    // divisor means the quotient reaches 2^QB.
    always_comb
    begin
        st_next[0].nx   = in_data.nx;
        st_next[0].ny   = in_data.ny;
        st_next[0].d    = in_data.d;
        st_next[0].negx = in_data.negx;
        st_next[0].negy = in_data.negy;
        st_next[0].grd  = in_data.grd;
        st_next[0].qx   = '0;
        st_next[0].qy   = '0;
        st_next[0].rx   = vrp_pkg::DEN_W'(in_data.nx[vrp_pkg::NUM_W-1 -: vrp_pkg::TOP_W]);
        st_next[0].ry   = vrp_pkg::DEN_W'(in_data.ny[vrp_pkg::NUM_W-1 -: vrp_pkg::TOP_W]);
        st_next[0].ovfx = (st_next[0].rx >= in_data.d);
        st_next[0].ovfy = (st_next[0].ry >= in_data.d);
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_st
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
            assign ld[k]  = rdy[k] && up_vld[k];

            if (k > 0)
            begin : g_step
                logic [vrp_pkg::DEN_W:0] sx, sy;
                assign sx = div_step(st_reg[k-1].rx, st_reg[k-1].nx[vrp_pkg::QB-k],
                                     st_reg[k-1].d);
                assign sy = div_step(st_reg[k-1].ry, st_reg[k-1].ny[vrp_pkg::QB-k],
                                     st_reg[k-1].d);
                always_comb
                begin
                    st_next[k]                  = st_reg[k-1];
                    st_next[k].rx               = sx[vrp_pkg::DEN_W-1:0];
                    st_next[k].ry               = sy[vrp_pkg::DEN_W-1:0];
                    st_next[k].qx[vrp_pkg::QB-k] = sx[vrp_pkg::DEN_W];
                    st_next[k].qy[vrp_pkg::QB-k] = sy[vrp_pkg::DEN_W];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ld[k])
                begin
                    st_reg[k] <= st_next[k];
                end
            end
        end
    endgenerate

    assign in_ready       = rdy[0];
    assign out_valid      = vld_reg[NS-1];
    assign out_data.qx    = st_reg[NS-1].qx;
    assign out_data.qy    = st_reg[NS-1].qy;
    assign out_data.ovfx  = st_reg[NS-1].ovfx;
    assign out_data.ovfy  = st_reg[NS-1].ovfy;
    assign out_data.negx  = st_reg[NS-1].negx;
    assign out_data.negy  = st_reg[NS-1].negy;
    assign out_data.grd   = st_reg[NS-1].grd;

endmodule

[hw/rtl/vrp_screen.sv]
`timescale 1ns / 1ps

module vrp_screen (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vrp_pkg::vrp_div_out_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    sx,
    output logic signed [31:0]    sy,
    output logic                  grd,
    output logic                  clip
);

    localparam int NS = 3;
    localparam logic signed [vrp_pkg::SIDE_W:0] SIDE_S = (vrp_pkg::SIDE_W + 1)'(vrp_pkg::MIN_SIDE);

    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] up_vld;
    logic [NS-1:0] ld;

    assign rdy[NS] = out_ready;
    assign up_vld  = {vld_reg[NS-2:0], in_valid};

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_hs
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
            assign ld[k]  = rdy[k] && up_vld[k];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (up_vld & rdy[NS-1:0]) | (vld_reg & ~rdy[NS-1:0]);
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NS-1];

    // Stage 1: clamp quotient magnitude to 2^40, restore sign
    logic [vrp_pkg::QB-1:0]            magx, magy;
    logic signed [vrp_pkg::QS_W-1:0]   qsx_reg, qsy_reg;
    logic signed [vrp_pkg::QS_W-1:0]   qsx_next, qsy_next;
    logic                              g1_reg;

    always_comb
    begin
        magx     = (in_data.ovfx || in_data.qx > vrp_pkg::Q_LIMIT) ? vrp_pkg::Q_LIMIT : in_data.qx;
        magy     = (in_data.ovfy || in_data.qy > vrp_pkg::Q_LIMIT) ? vrp_pkg::Q_LIMIT : in_data.qy;
        qsx_next = in_data.negx ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
        qsy_next = in_data.negy ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            qsx_reg <= qsx_next;
            qsy_reg <= qsy_next;
            g1_reg  <= in_data.grd;
        end
    end

    // Stage 2: scale by the shorter screen side
    logic signed [vrp_pkg::PR_W-1:0] px_reg, py_reg;
    logic                            g2_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            px_reg <= qsx_reg * SIDE_S;
            py_reg <= qsy_reg * SIDE_S;
            g2_reg <= g1_reg;
        end
    end

    // Stage 3: center and saturate; this is the output register
    logic signed [vrp_pkg::SCR_W-1:0] fx, fy;
    logic                             hix, lox, hiy, loy;
    logic signed [31:0]               sx_reg, sy_reg, sx_next, sy_next;
    logic                             grd_reg, clip_reg;

    always_comb
    begin
        fx      = px_reg + vrp_pkg::HALF_W_Q;
        fy      = vrp_pkg::HALF_H_Q - py_reg;
        hix     = fx > vrp_pkg::SAT_HI;
        lox     = fx < vrp_pkg::SAT_LO;
        hiy     = fy > vrp_pkg::SAT_HI;
        loy     = fy < vrp_pkg::SAT_LO;
        sx_next = hix ? vrp_pkg::SAT_HI[31:0] : (lox ? vrp_pkg::SAT_LO[31:0] : fx[31:0]);
        sy_next = hiy ? vrp_pkg::SAT_HI[31:0] : (loy ? vrp_pkg::SAT_LO[31:0] : fy[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            grd_reg  <= g2_reg;
            clip_reg <= hix || lox || hiy || loy;
        end
    end

    assign sx   = sx_reg;
    assign sy   = sy_reg;
    assign grd  = grd_reg;
    assign clip = clip_reg;

endmodule

[hw/rtl/vertex_rotate_project.sv]
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// input     in_valid / in_stall      vertex_x, vertex_y, vertex_z
// output    out_valid / out_stall    screen_x, screen_y, depth_guarded, clipped_flag
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One vertex a cycle while out_stall is low; 6 rotate/translate stages, 42 divider
// stages (a seed stage, then one quotient bit per stage for both x and y), 3 screen stages.
// rst_n clears every valid bit and loads the register reset values asynchronously.
// A stall fills bubbles first; in_stall rises only once every stage holds a vertex
// and the output transfer is held off.
// cfg_ready is always high; write registers only while the pipeline is empty.

module vertex_rotate_project (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [vrp_pkg::IN_W-1:0]    vertex_x,
    input  logic signed [vrp_pkg::IN_W-1:0]    vertex_y,
    input  logic signed [vrp_pkg::IN_W-1:0]    vertex_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 screen_x,
    output logic signed [31:0]                 screen_y,
    output logic                               depth_guarded,
    output logic                               clipped_flag,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vrp_pkg::IDX_W-1:0]          cfg_index,
    input  logic [31:0]                        cfg_data
);

    // Configuration registers, written on a config transfer
    vrp_pkg::vrp_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pitch_cos   <= 16'sd16384;
            cfg_reg.pitch_sin   <= '0;
            cfg_reg.yaw_cos     <= 16'sd16384;
            cfg_reg.yaw_sin     <= '0;
            cfg_reg.translate_x <= '0;
            cfg_reg.translate_y <= '0;
            cfg_reg.translate_z <= 32'sd327680;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vrp_pkg::REG_PITCH_COS:   cfg_reg.pitch_cos   <= cfg_data[15:0];
                vrp_pkg::REG_PITCH_SIN:   cfg_reg.pitch_sin   <= cfg_data[15:0];
                vrp_pkg::REG_YAW_COS:     cfg_reg.yaw_cos     <= cfg_data[15:0];
                vrp_pkg::REG_YAW_SIN:     cfg_reg.yaw_sin     <= cfg_data[15:0];
                vrp_pkg::REG_TRANSLATE_X: cfg_reg.translate_x <= cfg_data;
                vrp_pkg::REG_TRANSLATE_Y: cfg_reg.translate_y <= cfg_data;
                vrp_pkg::REG_TRANSLATE_Z: cfg_reg.translate_z <= cfg_data;
                default:                  ; // drop writes to unused index
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Rotate, translate, split into sign and magnitude
    logic                 rot_in_ready;
    logic                 rot_valid, div_in_ready;
    vrp_pkg::vrp_div_in_t rot_data;

    vrp_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (rot_in_ready),
        .vx        (vertex_x),
        .vy        (vertex_y),
        .vz        (vertex_z),
        .out_valid (rot_valid),
        .out_ready (div_in_ready),
        .out_data  (rot_data)
    );

    assign in_stall = !rot_in_ready;

    // Divide x and y by depth: a seed stage, then one quotient bit per stage
    logic                  div_valid, scr_in_ready;
    vrp_pkg::vrp_div_out_t div_data;

    vrp_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (div_in_ready),
        .in_data   (rot_data),
        .out_valid (div_valid),
        .out_ready (scr_in_ready),
        .out_data  (div_data)
    );

    // Clamp, scale, center, saturate; last stage is the output register
    vrp_screen u_screen (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (scr_in_ready),
        .in_data   (div_data),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .sx        (screen_x),
        .sy        (screen_y),
        .grd       (depth_guarded),
        .clip      (clipped_flag)
    );

endmodule

[hw/rtl/vrp_checker.sv]
`timescale 1ns / 1ps

`include "vertex_rotate_project_defines.svh"

module vrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] screen_x,
    input logic [31:0] screen_y,
    input logic        clipped_flag,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // Input holds off only when the whole pipeline backs up behind the output
    `VRP_ASSERT_IMP(a_stall_backup, in_stall, out_valid && out_stall,
                    "input stalled without output backpressure")

    // A clipped result sits on a saturation bound
    `VRP_ASSERT_IMP(a_clip_bound, out_valid && clipped_flag,
                    screen_x == 32'h7FFF_FFFF || screen_x == 32'h8000_0000 ||
                    screen_y == 32'h7FFF_FFFF || screen_y == 32'h8000_0000,
                    "clip flag without saturated value")

    // Config writes are never refused
    `VRP_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

    // A held result stays valid
    `VRP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .clipped_flag (clipped_flag),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

[sim/vrp_checker.sv]
`timescale 1ns / 1ps

module vrp_tb_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] vertex_x,
    input  logic signed [31:0] vertex_y,
    input  logic signed [31:0] vertex_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] screen_x,
    input  logic signed [31:0] screen_y,
    input  logic               depth_guarded,
    input  logic               clipped_flag,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 seen_guard,
    output int                 seen_clip
);
    import vrp_pkg::*;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               grd;
        logic               clp;
    } pixel_t;

    pixel_t pixel_q[$];
    longint c_pc, c_ps, c_yc, c_ys, c_tx, c_ty, c_tz;

    function automatic longint round14(longint acc);
        return (acc + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clamp32(longint v, inout logic clp);
        if (v > 64'sd2147483647) begin clp = 1'b1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin clp = 1'b1; return -64'sd2147483648; end
        return v;
    endfunction

    function automatic pixel_t project_vertex(longint x, longint y, longint z);
        longint y1, z1, x2, z2, qx, qy, lim;
        pixel_t p;
        logic   clp;
        lim = 64'sd1 <<< 40;
        clp = 1'b0;
        p.grd = 1'b0;
        y1 = round14(y * c_pc - z * c_ps);
        z1 = round14(y * c_ps + z * c_pc);
        x2 = round14(x * c_yc + z1 * c_ys) + c_tx;
        z2 = round14(z1 * c_yc - x * c_ys) + c_tz;
        y1 = y1 + c_ty;
        if (z2 == 0) begin z2 = 1; p.grd = 1'b1; end
        qx = (x2 * 65536) / z2;
        qy = (y1 * 65536) / z2;
        if (qx > lim) qx = lim;
        if (qx < -lim) qx = -lim;
        if (qy > lim) qy = lim;
        if (qy < -lim) qy = -lim;
        p.sx = 32'(clamp32(qx * MIN_SIDE + longint'(SCREEN_WIDTH) * 32768, clp));
        p.sy = 32'(clamp32(-qy * MIN_SIDE + longint'(SCREEN_HEIGHT) * 32768, clp));
        p.clp = clp;
        return p;
    endfunction

    assign pending = pixel_q.size();

    always @(posedge clk or negedge rst_n) begin
        pixel_t exp_p;
        if (!rst_n) begin
            c_pc = 16384; c_ps = 0; c_yc = 16384; c_ys = 0;
            c_tx = 0; c_ty = 0; c_tz = 327680;
            fail_count = 0; seen_guard = 0; seen_clip = 0;
            pixel_q.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h", $realtime, screen_x, screen_y);
                    fail_count++;
                end
                else begin
                    exp_p = pixel_q.pop_front();
                    if (screen_x !== exp_p.sx) begin
                        $display("%0t: screen_x exp %h got %h", $realtime, exp_p.sx, screen_x);
                        fail_count++;
                    end
                    if (screen_y !== exp_p.sy) begin
                        $display("%0t: screen_y exp %h got %h", $realtime, exp_p.sy, screen_y);
                        fail_count++;
                    end
                    if (depth_guarded !== exp_p.grd) begin
                        $display("%0t: depth_guarded exp %b got %b", $realtime, exp_p.grd,
                                 depth_guarded);
                        fail_count++;
                    end
                    if (clipped_flag !== exp_p.clp) begin
                        $display("%0t: clipped_flag exp %b got %b", $realtime, exp_p.clp,
                                 clipped_flag);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                exp_p = project_vertex(vertex_x, vertex_y, vertex_z);
                seen_guard += exp_p.grd;
                seen_clip += exp_p.clp;
                pixel_q = {pixel_q, exp_p};
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PITCH_COS:   c_pc = longint'($signed(cfg_data[15:0]));
                    REG_PITCH_SIN:   c_ps = longint'($signed(cfg_data[15:0]));
                    REG_YAW_COS:     c_yc = longint'($signed(cfg_data[15:0]));
                    REG_YAW_SIN:     c_ys = longint'($signed(cfg_data[15:0]));
                    REG_TRANSLATE_X: c_tx = longint'($signed(cfg_data));
                    REG_TRANSLATE_Y: c_ty = longint'($signed(cfg_data));
                    REG_TRANSLATE_Z: c_tz = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
        end
    end
endmodule

[sim/vertex_rotate_project_tb.sv]
`timescale 1ns / 1ps

module vertex_rotate_project_tb;
    import vrp_pkg::*;

    localparam int LATENCY = 51;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] vertex_x = '0;
    logic signed [31:0] vertex_y = '0;
    logic signed [31:0] vertex_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               depth_guarded;
    logic               clipped_flag;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    int fail_count, pending, seen_guard, seen_clip;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int vertex_total = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    vertex_rotate_project uut (.*);

    vrp_tb_checker chk (.*);

    // Randomly hold off the output transfer.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Present one vertex, then hold it until the transfer happens.
    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vertex_x <= x;
        vertex_y <= y;
        vertex_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        vertex_total++;
    endtask

    // Drop valid and wait for the pipeline to drain before touching registers.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Hold valid high across back-to-back writes; the caller drops it.
    task automatic write_reg(input vrp_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_angles(input logic [15:0] pc, input logic [15:0] ps,
                               input logic [15:0] yc, input logic [15:0] ys,
                               input logic [31:0] tx, input logic [31:0] ty,
                               input logic [31:0] tz);
        write_reg(REG_PITCH_COS, {16'($urandom), pc});
        write_reg(REG_PITCH_SIN, {16'($urandom), ps});
        write_reg(REG_YAW_COS, {16'($urandom), yc});
        write_reg(REG_YAW_SIN, {16'($urandom), ys});
        write_reg(REG_TRANSLATE_X, tx);
        write_reg(REG_TRANSLATE_Y, ty);
        write_reg(REG_TRANSLATE_Z, tz);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000 ^ $urandom_range(3);
            2: return 32'h7FFF_FFFF - $urandom_range(3);
            default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    // Mostly an x or y translation within +/-20.0, sometimes anything.
    function automatic logic [31:0] pick_shift();
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
    endfunction

    initial
    begin
        logic [15:0] c, s;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default setup, field extremes, zero depth, overflow.
        send_vertex(0, 0, 0);
        send_vertex(0, 0, -32'sd327680);
        send_vertex(32'h0001_0000, 32'h0001_0000, -32'sd327680);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, -32'sd327679);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000);
        send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        // Extreme coefficients and translations, including values outside +/-1.0.
        load_angles(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(0, 0, 0);
        drain();
        load_angles(16'hC000, 16'h4000, 16'h0000, 16'hC000, 0, 0, 0);
        send_vertex(0, 0, 0);
        send_vertex(32'h0002_0000, 32'h0003_0000, 32'h0000_0000);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
        drain();

        // Random phases: idle mix changes every third of the run.
        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph < 5) begin send_idle_pct = 7; recv_idle_pct = 46; end
            else if (ph < 10) begin send_idle_pct = 46; recv_idle_pct = 7; end
            else begin send_idle_pct = 0; recv_idle_pct = 0; end
            case (ph % 4)
                0: load_angles(16'h4000, 16'h0000, 16'h4000, 16'h0000, 0, 0, 32'h0005_0000);
                1: load_angles(16'hC000, 16'h0000, 16'h0000, 16'h4000,
                               $urandom, $urandom, $urandom);
                default:
                begin
                    c = 16'($signed($urandom_range(32768)) - 16384);
                    s = 16'($signed($urandom_range(32768)) - 16384);
                    load_angles(c, s, s, c, pick_shift(), pick_shift(),
                                32'($urandom_range(30 << 16)));
                end
            endcase
            for (int i = 0; i < 100; i++)
            begin
                send_vertex(pick_coord(), pick_coord(), pick_coord());
                // Once, midway through the third phase, pause the source until the pipeline is empty.
                if (i == 50 && ph == 2)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        $display("covered %0d vertices over 16 register settings, %0d zero-depth, %0d clipped",
                 vertex_total, seen_guard, seen_clip);
        if (fail_count == 0)
            $display("** vertex_rotate_project: PASSED **");
        else
            $display("** vertex_rotate_project: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** vertex_rotate_project: FAILED **");
        $finish;
    end
endmodule
